// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// File: rtl/cfpr_pkg.sv
// Shared types and constants of the circle-follow PID rate unit.
package cfpr_pkg;

  localparam int GAIN_W      = 24;
  localparam int SPEED_W     = 14;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int RAD_W       = 34;  // radicand: dx*dx + dy*dy
  localparam int ROOT_W      = 17;
  localparam int OP_A_W      = 25;
  localparam int OP_B_W      = 19;
  localparam int ACC_W       = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED = 4'd3;

  localparam logic [GAIN_W-1:0]  GAIN_P_RESET    = 24'd37749;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 14'd5120;

  typedef logic signed [OP_A_W-1:0]        op_a_t;
  typedef logic signed [OP_B_W-1:0]        op_b_t;
  typedef logic signed [OP_A_W+OP_B_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]         acc_t;

  typedef struct packed {
    logic issue;  // operands valid this cycle
    logic clear;  // start a fresh sum with this product
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // last step is taken at this edge
  } sqrt_stat_t;

endpackage

// File: rtl/cfpr_mac.sv
// Shared two-stage multiply-accumulate unit.
module cfpr_mac (
  input  logic               clk,
  input  logic               rst,
  input  cfpr_pkg::mac_ctl_t ctl,
  input  cfpr_pkg::op_a_t    op_a,
  input  cfpr_pkg::op_b_t    op_b,
  output cfpr_pkg::acc_t     acc
);

  cfpr_pkg::prod_t prod;
  logic            p_issue;
  logic            p_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_issue <= 1'b0;
    end else begin
      p_issue <= ctl.issue;
    end
    p_clear <= ctl.clear;
    prod    <= op_a * op_b;
    if (p_issue) begin
      acc <= (p_clear ? '0 : acc) + cfpr_pkg::acc_t'(prod);
    end
  end

endmodule

// File: rtl/cfpr_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module cfpr_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cfpr_pkg::RAD_W-1:0]   radicand,
  output cfpr_pkg::sqrt_stat_t         stat,
  output logic [cfpr_pkg::ROOT_W-1:0]  root
);

  localparam int W = cfpr_pkg::RAD_W;

  logic         run;
  logic [W-1:0] rem;
  logic [W:0]   rt;
  logic [W-1:0] bitm;
  logic [W:0]   trial;

  assign trial     = rt + {1'b0, bitm};
  assign stat.busy = run;
  assign stat.done = run && (bitm == W'(1));
  assign root      = rt[cfpr_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (stat.done) begin
      run <= 1'b0;
    end
    if (start) begin
      rem  <= radicand;
      rt   <= '0;
      bitm <= W'(1) << (W - 2);
    end else if (run) begin
      // take the digit when the remainder covers the trial value
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[W-1:0];
        rt  <= (rt >> 1) + {1'b0, bitm};
      end else begin
        rt  <= rt >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// File: rtl/circle_follow_pid_rate_unit.sv
// Top level of the circle-follow PID rate unit: sequencer, state and registers.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | to block  | in_valid / in_stall | robot_x, robot_y, center_x, center_y,
//          |           |                     | radius, enable
//  out     | from block| out_valid/out_stall | rot_vel
//  cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// An item passes from the accepting edge to out_valid through the two squares in the shared
// multiply-accumulate unit, the bit-per-cycle square root, then error, three PID products,
// drain, rounding and output; in_stall is high throughout.
// Reset (rst, synchronous) loads the register defaults, clears the integrator and
// previous error, and empties the output register.
// A new transaction is taken while a result waits; a second result waits for out_stall.
`include "assert_macros.svh"

module circle_follow_pid_rate_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  robot_x,
  input  logic signed [15:0]                  robot_y,
  input  logic signed [15:0]                  center_x,
  input  logic signed [15:0]                  center_y,
  input  logic [14:0]                         radius,
  input  logic                                enable,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [14:0]                  rot_vel,
  input  logic                                cfg_we,
  input  logic [cfpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cfpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQ1  = 13'b0000000000010,
    S_SQ2  = 13'b0000000000100,
    S_SQW  = 13'b0000000001000,
    S_RTLD = 13'b0000000010000,
    S_RTWT = 13'b0000000100000,
    S_ERR  = 13'b0000001000000,
    S_PI   = 13'b0000010000000,
    S_PD   = 13'b0000100000000,
    S_PP   = 13'b0001000000000,
    S_PW   = 13'b0010000000000,
    S_RND  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [cfpr_pkg::GAIN_W-1:0]  gain_p, gain_i, gain_d;
  logic [cfpr_pkg::SPEED_W-1:0] speed_limit;

  // controller state
  logic signed [5:0]  accum;
  logic signed [17:0] prev_err;

  // per-transaction registers
  logic signed [16:0] dx, dy;
  logic [14:0]        rad;
  logic               en;
  logic signed [17:0] err;
  logic signed [18:0] diff;
  logic [32:0]        qmag;
  logic               neg;

  // shared units
  cfpr_pkg::mac_ctl_t   mac_ctl;
  cfpr_pkg::op_a_t      op_a;
  cfpr_pkg::op_b_t      op_b;
  cfpr_pkg::acc_t       acc;
  cfpr_pkg::sqrt_stat_t sq_stat;
  logic [cfpr_pkg::ROOT_W-1:0] root;

  // output-side helpers
  logic                         in_take;
  logic                         out_free;
  cfpr_pkg::acc_t               mag;
  logic [cfpr_pkg::SPEED_W-1:0] sat;
  logic signed [18:0]           acc_sum;
  logic signed [5:0]            accum_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  cfpr_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  cfpr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RTLD),
    .radicand (acc[cfpr_pkg::RAD_W-1:0]),
    .stat     (sq_stat),
    .root     (root)
  );

  // operand select for the shared multiplier
  always_comb begin
    mac_ctl.issue = 1'b0;
    mac_ctl.clear = 1'b0;
    op_a          = '0;
    op_b          = '0;
    case (state)
      S_SQ1: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        op_a          = cfpr_pkg::op_a_t'(dx);
        op_b          = cfpr_pkg::op_b_t'(dx);
      end
      S_SQ2: begin
        mac_ctl.issue = 1'b1;
        op_a          = cfpr_pkg::op_a_t'(dy);
        op_b          = cfpr_pkg::op_b_t'(dy);
      end
      S_PI: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clear = 1'b1;
        op_a          = $signed({1'b0, gain_i});
        op_b          = cfpr_pkg::op_b_t'(accum);
      end
      S_PD: begin
        mac_ctl.issue = 1'b1;
        op_a          = $signed({1'b0, gain_d});
        op_b          = diff;
      end
      S_PP: begin
        mac_ctl.issue = 1'b1;
        op_a          = $signed({1'b0, gain_p});
        op_b          = cfpr_pkg::op_b_t'(err);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SQ1;
      S_SQ1:  state_next = S_SQ2;
      S_SQ2:  state_next = S_SQW;
      S_SQW:  state_next = S_RTLD;
      S_RTLD: state_next = S_RTWT;
      S_RTWT: if (sq_stat.done) state_next = S_ERR;
      S_ERR:  state_next = S_PI;
      S_PI:   state_next = S_PD;
      S_PD:   state_next = S_PP;
      S_PP:   state_next = S_PW;
      S_PW:   state_next = S_RND;
      S_RND:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // magnitude of the sum, then clamp of the rounded value
  assign mag = acc[cfpr_pkg::ACC_W-1] ? -acc : acc;
  assign sat = (qmag > 33'(speed_limit)) ? speed_limit
                                         : qmag[cfpr_pkg::SPEED_W-1:0];

  // integrator update, clamped to one centimeter either way
  assign acc_sum = 19'(accum) + 19'(err);
  always_comb begin
    if (acc_sum > 19'sd16) begin
      accum_next = 6'sd16;
    end else if (acc_sum < -19'sd16) begin
      accum_next = -6'sd16;
    end else begin
      accum_next = acc_sum[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      gain_p      <= cfpr_pkg::GAIN_P_RESET;
      gain_i      <= '0;
      gain_d      <= '0;
      speed_limit <= cfpr_pkg::MAX_SPEED_RESET;
      accum       <= '0;
      prev_err    <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          cfpr_pkg::CFG_GAIN_P:    gain_p      <= cfg_data;
          cfpr_pkg::CFG_GAIN_I:    gain_i      <= cfg_data;
          cfpr_pkg::CFG_GAIN_D:    gain_d      <= cfg_data;
          cfpr_pkg::CFG_MAX_SPEED: speed_limit <= cfg_data[cfpr_pkg::SPEED_W-1:0];
          default: begin
          end
        endcase
      end

      // hand the result over and advance the controller state
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        accum     <= accum_next;
        prev_err  <= err;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end

    // payload registers
    if (in_take) begin
      dx  <= 17'(robot_x) - 17'(center_x);
      dy  <= 17'(robot_y) - 17'(center_y);
      rad <= radius;
      en  <= enable;
    end
    if (state == S_ERR) begin
      err <= $signed({1'b0, root}) - $signed({3'b000, rad});
    end
    if (state == S_PI) begin
      diff <= 19'(err) - 19'(prev_err);
    end
    if (state == S_RND) begin
      // round half away from zero on the magnitude
      qmag <= 33'((mag + cfpr_pkg::acc_t'(32768)) >>> 16);
      neg  <= acc[cfpr_pkg::ACC_W-1];
    end
    if (state == S_DONE && out_free) begin
      if (!en) begin
        rot_vel <= '0;
      end else if (neg) begin
        rot_vel <= -$signed({1'b0, sat});
      end else begin
        rot_vel <= $signed({1'b0, sat});
      end
    end
  end

  `ASSERT_CLK(a_accum_range, clk, rst, (accum <= 6'sd16) && (accum >= -6'sd16))
  `ASSERT_CLK(a_root_done_in_wait, clk, rst, sq_stat.done |-> (state == S_RTWT))
  `ASSERT_CLK(a_wait_has_root, clk, rst, (state == S_RTWT) |-> sq_stat.busy)
  `ASSERT_CLK(a_take_starts, clk, rst, in_take |=> (state == S_SQ1))

endmodule
